### rtl/hmd_pkg.sv
// hmd_pkg: shared types and constants for the headers message deframer
// no dependencies; imported by every module under rtl

package hmd_pkg;

   localparam int HDR_LEN = 128;

   localparam logic [11:0] MAX_HEADERS_RESET = 12'd2000;

   localparam logic [7:0] VARINT_PREFIX_U16 = 8'hFD;
   localparam logic [7:0] VARINT_PREFIX_U32 = 8'hFE;

   localparam logic [2:0] STATUS_OK          = 3'd0;
   localparam logic [2:0] STATUS_EMPTY       = 3'd1;
   localparam logic [2:0] STATUS_BAD_COUNT   = 3'd2;
   localparam logic [2:0] STATUS_OVER_LIMIT  = 3'd3;
   localparam logic [2:0] STATUS_TRUNCATED   = 3'd4;

   typedef struct packed {
      logic [7:0] data;
      logic       end_marker;
   } req_type;

   typedef struct packed {
      logic        header_byte_valid;
      logic [11:0] header_index;
      logic [6:0]  byte_offset;
      logic [7:0]  header_byte;
      logic        header_complete;
      logic        payload_done;
      logic [2:0]  status;
      logic [11:0] headers_parsed;
   } rsp_type;

   function automatic logic [3:0] varint_extra(input logic [7:0] prefix);
      logic [3:0] n;
      if (prefix == VARINT_PREFIX_U16) begin
         n = 4'd2;
      end else if (prefix == VARINT_PREFIX_U32) begin
         n = 4'd4;
      end else begin
         n = 4'd8;
      end
      return n;
   endfunction

endpackage

### rtl/hmd_csr.sv
// hmd_csr: max_headers configuration register with its write channel
// depends on hmd_pkg

module hmd_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [11:0] csr_data,
   output logic [11:0] max_headers
);
   import hmd_pkg::*;

   logic [11:0] max_ff;
   logic [11:0] max_in;

   assign csr_ready = 1'b1;

   always_comb begin
      max_in = max_ff;
      if (csr_valid && csr_ready) begin
         max_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= MAX_HEADERS_RESET;
      end else begin
         max_ff <= max_in;
      end
   end

   assign max_headers = max_ff;

endmodule

### rtl/hmd_parse.sv
// hmd_parse: payload state machine, decodes the count varint and tags header bytes
// depends on hmd_pkg; one beat is processed per step_en

module hmd_parse (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  hmd_pkg::req_type item,
   input  logic [11:0]      max_headers,
   output logic             res_valid,
   output hmd_pkg::rsp_type res
);
   import hmd_pkg::*;

   localparam logic [2:0] PH_COUNT_PREFIX = 3'd0;
   localparam logic [2:0] PH_COUNT_BYTES  = 3'd1;
   localparam logic [2:0] PH_HEADER       = 3'd2;
   localparam logic [2:0] PH_TX_PREFIX    = 3'd3;
   localparam logic [2:0] PH_TX_BYTES     = 3'd4;
   localparam logic [2:0] PH_DONE         = 3'd5;
   localparam logic [2:0] PH_ZERO         = 3'd6;
   localparam logic [2:0] PH_OVER         = 3'd7;

   localparam logic [6:0] LAST_OFFSET = 7'(HDR_LEN - 1);

   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  left_ff, left_in;
   logic [1:0]  pos_ff, pos_in;
   logic [11:0] cnt_lo_ff, cnt_lo_in;
   logic        cnt_hi_ff, cnt_hi_in;
   logic [6:0]  off_ff, off_in;
   logic [11:0] done_ff, done_in;
   logic        seen_ff, seen_in;

   always_comb begin
      logic        finish;
      logic [11:0] done_next;
      logic [2:0]  st;
      finish    = 1'b0;
      done_next = done_ff + 12'd1;
      st        = STATUS_TRUNCATED;
      phase_in  = phase_ff;
      left_in   = left_ff;
      pos_in    = pos_ff;
      cnt_lo_in = cnt_lo_ff;
      cnt_hi_in = cnt_hi_ff;
      off_in    = off_ff;
      done_in   = done_ff;
      seen_in   = seen_ff;
      res_valid = 1'b0;
      res       = '0;

      if (item.end_marker) begin
         if (!seen_ff) begin
            st = STATUS_EMPTY;
         end else if (phase_ff == PH_COUNT_BYTES || phase_ff == PH_ZERO) begin
            st = STATUS_BAD_COUNT;
         end else if (phase_ff == PH_OVER) begin
            st = STATUS_OVER_LIMIT;
         end else if (phase_ff == PH_DONE) begin
            st = STATUS_OK;
         end
         res_valid          = 1'b1;
         res.payload_done   = 1'b1;
         res.status         = st;
         res.headers_parsed = done_ff;
         phase_in  = PH_COUNT_PREFIX;
         left_in   = '0;
         pos_in    = '0;
         cnt_lo_in = '0;
         cnt_hi_in = 1'b0;
         off_in    = '0;
         done_in   = '0;
         seen_in   = 1'b0;
      end else begin
         seen_in = 1'b1;
         unique case (phase_ff)
            PH_COUNT_PREFIX: begin
               if (item.data < VARINT_PREFIX_U16) begin
                  cnt_lo_in = {4'd0, item.data};
                  cnt_hi_in = 1'b0;
                  finish    = 1'b1;
               end else begin
                  left_in   = varint_extra(item.data);
                  cnt_lo_in = '0;
                  cnt_hi_in = 1'b0;
                  pos_in    = '0;
                  phase_in  = PH_COUNT_BYTES;
               end
            end
            PH_COUNT_BYTES: begin
               case (pos_ff)
                  2'd0: cnt_lo_in[7:0] = item.data;
                  2'd1: begin
                     cnt_lo_in[11:8] = item.data[3:0];
                     cnt_hi_in       = cnt_hi_ff | (|item.data[7:4]);
                  end
                  default: cnt_hi_in = cnt_hi_ff | (|item.data);
               endcase
               pos_in = (pos_ff == 2'd2) ? 2'd2 : pos_ff + 2'd1;
               if (left_ff != 4'd0) begin
                  left_in = left_ff - 4'd1;
               end
               finish = (left_in == 4'd0);
            end
            PH_HEADER: begin
               res_valid             = 1'b1;
               res.header_byte_valid = 1'b1;
               res.header_index      = done_ff;
               res.byte_offset       = off_ff;
               res.header_byte       = item.data;
               off_in                = off_ff + 7'd1;
               if (off_ff == LAST_OFFSET) begin
                  res.header_complete = 1'b1;
                  off_in              = '0;
                  done_in             = done_next;
                  phase_in = (done_next >= cnt_lo_ff) ? PH_DONE : PH_TX_PREFIX;
               end
            end
            PH_TX_PREFIX: begin
               if (item.data < VARINT_PREFIX_U16) begin
                  phase_in = PH_HEADER;
               end else begin
                  left_in  = varint_extra(item.data);
                  phase_in = PH_TX_BYTES;
               end
            end
            PH_TX_BYTES: begin
               if (left_ff != 4'd0) begin
                  left_in = left_ff - 4'd1;
               end
               if (left_in == 4'd0) begin
                  phase_in = PH_HEADER;
               end
            end
            default: begin
            end
         endcase

         if (finish) begin
            if (cnt_lo_in == 12'd0 && !cnt_hi_in) begin
               phase_in = PH_ZERO;
            end else if (cnt_hi_in || cnt_lo_in > max_headers) begin
               phase_in = PH_OVER;
            end else begin
               phase_in = PH_HEADER;
               off_in   = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_COUNT_PREFIX;
         left_ff   <= '0;
         pos_ff    <= '0;
         cnt_lo_ff <= '0;
         cnt_hi_ff <= 1'b0;
         off_ff    <= '0;
         done_ff   <= '0;
         seen_ff   <= 1'b0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         left_ff   <= left_in;
         pos_ff    <= pos_in;
         cnt_lo_ff <= cnt_lo_in;
         cnt_hi_ff <= cnt_hi_in;
         off_ff    <= off_in;
         done_ff   <= done_in;
         seen_ff   <= seen_in;
      end
   end

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      step_en && item.end_marker |=> phase_ff == PH_COUNT_PREFIX && done_ff == 12'd0
         && !seen_ff)
      else $error("payload state not cleared after end beat");

   a_headers_below_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HEADER || phase_ff == PH_TX_PREFIX || phase_ff == PH_TX_BYTES)
         |-> done_ff < cnt_lo_ff && !cnt_hi_ff)
      else $error("header counter reached count while headers pending");

   a_varint_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_COUNT_BYTES || phase_ff == PH_TX_BYTES) |-> left_ff != 4'd0)
      else $error("varint phase with no bytes left");

   a_unseen_idle: assert property (@(posedge clock) disable iff (reset)
      !seen_ff |-> phase_ff == PH_COUNT_PREFIX && done_ff == 12'd0)
      else $error("state advanced with no byte seen");

endmodule

### rtl/headers_message_deframer.sv
// headers_message_deframer: top level with input register, parser and result register
// depends on hmd_pkg, hmd_csr, hmd_parse
//
//  channel  ports                              dir  beat
//  req      req_valid req_stall req_data       in   one payload byte or end marker
//  rsp      rsp_valid rsp_stall rsp_data       out  header byte or payload summary
//  csr      csr_valid csr_ready csr_data       in   max_headers write
//
//  one beat per cycle sustained while rsp_stall stays low; a taken beat's result reaches rsp
//  through the input register and then the result register around the parser
//  reset is synchronous; max_headers returns to 2000 and the payload state clears
//  req_stall rises only while a held beat waits on a stalled result register
//  count, tx-count and trailing bytes and the bytes of rejected payloads give no rsp beat

module headers_message_deframer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hmd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hmd_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [11:0]      csr_data
);
   import hmd_pkg::*;

   logic        in_valid_ff, in_valid_in;
   req_type     in_data_ff, in_data_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_data_ff, out_data_in;
   logic [11:0] max_headers;
   logic        out_free;
   logic        advance;
   logic        res_valid;
   rsp_type     res;

   hmd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .max_headers (max_headers)
   );

   hmd_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .step_en     (advance),
      .item        (in_data_ff),
      .max_headers (max_headers),
      .res_valid   (res_valid),
      .res         (res)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         if (req_valid) begin
            in_data_in = req_data;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_free) begin
         out_valid_in = advance && res_valid;
         if (advance && res_valid) begin
            out_data_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff)
      else $error("input stalled with room downstream");

   a_result_kind: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_data_ff.header_byte_valid != out_data_ff.payload_done)
      else $error("result beat is neither header byte nor summary");

   a_held_beat: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |=> out_valid_ff && $stable(out_data_ff))
      else $error("stalled result changed");

endmodule
